// File: hw/rtl/qmm_pkg.sv
package qmm_pkg;

  localparam int ThrW  = 8;
  localparam int AltW  = 9;
  localparam int DemW  = 13;
  localparam int CosW  = 10;
  localparam int MotW  = 15;
  localparam int ProdW = DemW + CosW;
  localparam int RotW  = 16;
  localparam int SwgW  = 15;
  localparam int QuoW  = 8;
  localparam int ScW   = QuoW + 1;
  localparam int NDiv  = QuoW;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Nine tenths as a multiplication by a 16-bit reciprocal of ten.
  localparam int HiRecip = 9 * 6554;

  localparam logic [ThrW-1:0]        IdleReset = 8'd10;
  localparam logic [ThrW-1:0]        OmaxReset = 8'd200;
  localparam logic signed [CosW-1:0] CosReset  = 10'sd256;
  localparam logic signed [CosW-1:0] SinReset  = 10'sd0;

  typedef enum logic [2:0] {
    RegIdle,
    RegOmax,
    RegRotate,
    RegCos,
    RegSin
  } reg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]        idle;
    logic [ThrW-1:0]        omax;
    logic                   rot;
    logic signed [CosW-1:0] cs;
    logic signed [CosW-1:0] sn;
  } cfg_t;

  typedef struct packed {
    logic [ThrW-1:0]        thr;
    logic                   active;
    logic                   need;
    logic signed [RotW-1:0] roll;
    logic signed [RotW-1:0] pitch;
    logic signed [DemW-1:0] yaw;
    logic [SwgW-1:0]        swing;
    logic [SwgW-1:0]        rem;
    logic [QuoW-1:0]        quo;
  } dstage_t;

  // One restoring division step: one quotient bit of headroom*256/swing.
  function automatic dstage_t div_step(dstage_t s);
    dstage_t    r;
    logic [SwgW:0] rem2;
    r    = s;
    rem2 = {s.rem, 1'b0};
    if (rem2 >= {1'b0, s.swing}) begin
      r.rem = SwgW'(rem2 - {1'b0, s.swing});
      r.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = rem2[SwgW-1:0];
      r.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/qmm_if.sv
interface qmm_in_if import qmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ThrW-1:0]        desired_throttle;
  logic signed [AltW-1:0] altitude_correction;
  logic                   in_flight;
  logic signed [DemW-1:0] roll_demand;
  logic signed [DemW-1:0] pitch_demand;
  logic signed [DemW-1:0] yaw_demand;

  modport source (
    output valid, desired_throttle, altitude_correction, in_flight,
           roll_demand, pitch_demand, yaw_demand,
    input  ready
  );
  modport sink (
    input  valid, desired_throttle, altitude_correction, in_flight,
           roll_demand, pitch_demand, yaw_demand,
    output ready
  );
endinterface

interface qmm_out_if import qmm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [MotW-1:0] front_motor;
  logic signed [MotW-1:0] back_motor;
  logic signed [MotW-1:0] left_motor;
  logic signed [MotW-1:0] right_motor;
  logic                   demand_rescaled;
  logic [ThrW-1:0]        effective_throttle;

  modport source (
    output valid, front_motor, back_motor, left_motor, right_motor,
           demand_rescaled, effective_throttle,
    input  ready
  );
  modport sink (
    input  valid, front_motor, back_motor, left_motor, right_motor,
           demand_rescaled, effective_throttle,
    output ready
  );
endinterface

// File: hw/rtl/qmm_pipe.sv
module qmm_pipe import qmm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  qmm_in_if.sink       in_i,
  qmm_out_if.source    out_o
);

  localparam int NStg   = NDiv + 6;
  localparam int DivIdx = 3;
  localparam int MulIdx = NStg - 2;
  localparam int OutIdx = NStg - 1;
  localparam int MrW    = RotW + ScW;
  localparam int MyW    = DemW + ScW;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[OutIdx] = !v_q[OutIdx] || out_o.ready;
    for (int k = OutIdx - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[OutIdx];

  // Input register.
  logic [ThrW-1:0]        s1_thr_q;
  logic signed [AltW-1:0] s1_alt_q;
  logic                   s1_fly_q;
  logic signed [DemW-1:0] s1_roll_q, s1_pitch_q, s1_yaw_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_thr_q   <= in_i.desired_throttle;
      s1_alt_q   <= in_i.altitude_correction;
      s1_fly_q   <= in_i.in_flight;
      s1_roll_q  <= in_i.roll_demand;
      s1_pitch_q <= in_i.pitch_demand;
      s1_yaw_q   <= in_i.yaw_demand;
    end
  end

  // Throttle cut and clamp, rotation products.
  logic [ThrW+15:0]        hi_prod;
  logic [ThrW-1:0]         hi;
  logic signed [ThrW+1:0]  thr_sum;
  logic [ThrW-1:0]         s2_thr_d;
  logic signed [ProdW-1:0] s2_pc_d, s2_rs_d, s2_rc_d, s2_ps_d;

  assign hi_prod = cfg_i.omax * 16'(HiRecip);
  assign hi      = hi_prod[ThrW+15:16];
  assign thr_sum = $signed({2'b00, s1_thr_q}) + (ThrW+2)'(s1_alt_q);

  always_comb begin
    if (s1_thr_q < cfg_i.idle) begin
      s2_thr_d = '0;
    end else if (!s1_fly_q) begin
      s2_thr_d = s1_thr_q;
    end else if (thr_sum < $signed({2'b00, cfg_i.idle})) begin
      s2_thr_d = cfg_i.idle;
    end else if (thr_sum > $signed({2'b00, hi})) begin
      s2_thr_d = hi;
    end else begin
      s2_thr_d = thr_sum[ThrW-1:0];
    end
  end

  assign s2_pc_d = ProdW'(s1_pitch_q) * ProdW'(cfg_i.cs);
  assign s2_rs_d = ProdW'(s1_roll_q) * ProdW'(cfg_i.sn);
  assign s2_rc_d = ProdW'(s1_roll_q) * ProdW'(cfg_i.cs);
  assign s2_ps_d = ProdW'(s1_pitch_q) * ProdW'(cfg_i.sn);

  logic [ThrW-1:0]         s2_thr_q;
  logic                    s2_act_q;
  logic signed [ProdW-1:0] s2_pc_q, s2_rs_q, s2_rc_q, s2_ps_q;
  logic signed [DemW-1:0]  s2_roll_q, s2_pitch_q, s2_yaw_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_thr_q   <= s2_thr_d;
      s2_act_q   <= s2_thr_d > cfg_i.idle;
      s2_pc_q    <= s2_pc_d;
      s2_rs_q    <= s2_rs_d;
      s2_rc_q    <= s2_rc_d;
      s2_ps_q    <= s2_ps_d;
      s2_roll_q  <= s1_roll_q;
      s2_pitch_q <= s1_pitch_q;
      s2_yaw_q   <= s1_yaw_q;
    end
  end

  // Rotation sums with a floor shift.
  logic signed [ProdW:0]  np_sum, nr_sum;
  logic signed [RotW-1:0] s3_roll_d, s3_pitch_d;

  assign np_sum = (ProdW+1)'(s2_pc_q) + (ProdW+1)'(s2_rs_q);
  assign nr_sum = (ProdW+1)'(s2_rc_q) - (ProdW+1)'(s2_ps_q);

  always_comb begin
    if (cfg_i.rot) begin
      s3_pitch_d = np_sum[ProdW -: RotW];
      s3_roll_d  = nr_sum[ProdW -: RotW];
    end else begin
      s3_pitch_d = RotW'(s2_pitch_q);
      s3_roll_d  = RotW'(s2_roll_q);
    end
  end

  logic [ThrW-1:0]        s3_thr_q;
  logic                   s3_act_q;
  logic signed [RotW-1:0] s3_roll_q, s3_pitch_q;
  logic signed [DemW-1:0] s3_yaw_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_thr_q   <= s2_thr_q;
      s3_act_q   <= s2_act_q;
      s3_roll_q  <= s3_roll_d;
      s3_pitch_q <= s3_pitch_d;
      s3_yaw_q   <= s2_yaw_q;
    end
  end

  // Swing above throttle and the smaller headroom.
  logic signed [RotW-1:0] yw, c0, c1, c2, c3, mx01, mx23, mx;
  logic signed [ThrW:0]   dh;
  logic [ThrW-1:0]        dh_abs, dl, hm;
  dstage_t                st0_d;

  always_comb begin
    yw     = RotW'(s3_yaw_q);
    c0     = yw - s3_pitch_q;
    c1     = yw + s3_pitch_q;
    c2     = -yw - s3_roll_q;
    c3     = s3_roll_q - yw;
    mx01   = (c1 > c0) ? c1 : c0;
    mx23   = (c3 > c2) ? c3 : c2;
    mx     = (mx23 > mx01) ? mx23 : mx01;
    dh     = $signed({1'b0, cfg_i.omax}) - $signed({1'b0, s3_thr_q});
    dh_abs = (dh < 0) ? ThrW'(-dh) : dh[ThrW-1:0];
    dl     = s3_thr_q - cfg_i.idle;
    hm     = (dh_abs < dl) ? dh_abs : dl;

    st0_d        = '0;
    st0_d.thr    = s3_thr_q;
    st0_d.active = s3_act_q;
    st0_d.need   = s3_act_q && (mx > 0) && (SwgW'(hm) < mx[SwgW-1:0]);
    st0_d.roll   = s3_roll_q;
    st0_d.pitch  = s3_pitch_q;
    st0_d.yaw    = s3_yaw_q;
    st0_d.swing  = mx[SwgW-1:0];
    st0_d.rem    = SwgW'(hm);
  end

  // Scale factor, one quotient bit per stage.
  dstage_t st_q [0:NDiv];

  always_ff @(posedge clk_i) begin
    if (en[DivIdx]) begin
      st_q[0] <= st0_d;
    end
    for (int j = 1; j <= NDiv; j++) begin
      if (en[DivIdx+j]) begin
        st_q[j] <= div_step(st_q[j-1]);
      end
    end
  end

  // Demand scaling products.
  logic signed [ScW-1:0] sc;

  assign sc = $signed({1'b0, (st_q[NDiv].quo == '0) ? QuoW'(1) : st_q[NDiv].quo});

  logic signed [MrW-1:0]  mr_q, mp_q;
  logic signed [MyW-1:0]  my_q;
  logic [ThrW-1:0]        mu_thr_q;
  logic                   mu_act_q, mu_need_q;
  logic signed [RotW-1:0] mu_roll_q, mu_pitch_q;
  logic signed [DemW-1:0] mu_yaw_q;

  always_ff @(posedge clk_i) begin
    if (en[MulIdx]) begin
      mr_q       <= MrW'(st_q[NDiv].roll) * MrW'(sc);
      mp_q       <= MrW'(st_q[NDiv].pitch) * MrW'(sc);
      my_q       <= MyW'(st_q[NDiv].yaw) * MyW'(sc);
      mu_thr_q   <= st_q[NDiv].thr;
      mu_act_q   <= st_q[NDiv].active;
      mu_need_q  <= st_q[NDiv].need;
      mu_roll_q  <= st_q[NDiv].roll;
      mu_pitch_q <= st_q[NDiv].pitch;
      mu_yaw_q   <= st_q[NDiv].yaw;
    end
  end

  // Final mix.
  logic signed [RotW-1:0] rr, pp, yy, tt;
  logic signed [RotW-1:0] fr_d, bk_d, lf_d, rt_d;

  always_comb begin
    rr = mu_need_q ? mr_q[MrW-2 -: RotW] : mu_roll_q;
    pp = mu_need_q ? mp_q[MrW-2 -: RotW] : mu_pitch_q;
    yy = mu_need_q ? RotW'($signed(my_q[MyW-2 -: DemW])) : RotW'(mu_yaw_q);
    tt = $signed(RotW'(mu_thr_q));
    if (mu_act_q) begin
      fr_d = tt - pp + yy;
      bk_d = tt + pp + yy;
      lf_d = tt - rr - yy;
      rt_d = tt + rr - yy;
    end else begin
      fr_d = tt;
      bk_d = tt;
      lf_d = tt;
      rt_d = tt;
    end
  end

  logic signed [MotW-1:0] fr_q, bk_q, lf_q, rt_q;
  logic                   resc_q;
  logic [ThrW-1:0]        thr_q;

  always_ff @(posedge clk_i) begin
    if (en[OutIdx]) begin
      fr_q   <= fr_d[MotW-1:0];
      bk_q   <= bk_d[MotW-1:0];
      lf_q   <= lf_d[MotW-1:0];
      rt_q   <= rt_d[MotW-1:0];
      resc_q <= mu_need_q;
      thr_q  <= mu_thr_q;
    end
  end

  assign out_o.front_motor        = fr_q;
  assign out_o.back_motor         = bk_q;
  assign out_o.left_motor         = lf_q;
  assign out_o.right_motor        = rt_q;
  assign out_o.demand_rescaled    = resc_q;
  assign out_o.effective_throttle = thr_q;

`ifndef NO_ASSERTIONS
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[0] |-> (&v_q))
    else $error("input refused while the pipeline has a free stage");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DivIdx] && !en[DivIdx]) |=> (v_q[DivIdx] && $stable(st_q[0])))
    else $error("stalled stage lost or changed its item");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[MulIdx-1] && st_q[NDiv].need) |-> (st_q[NDiv].rem < st_q[NDiv].swing))
    else $error("division remainder not below the swing");
`endif

endmodule

// File: hw/rtl/quad_motor_mixer_with_headroom_rescale_core.sv
// Plus-frame quadcopter motor mixer with headroom rescaling.
//
// Input transfers on in_i carry the pilot throttle, the altitude correction,
// the in-flight flag and the roll, pitch and yaw demands. Each one gives
// exactly one transfer on out_o with the four motor commands, the rescale
// flag and the effective throttle, in order.
// The pipeline has fourteen register stages, and while out_o is not stalled
// one item can be taken in every cycle. The depth is set by the eight
// division stages that form the Q8 scale factor, one quotient bit per
// stage, and by the two multiplier stages.
// Valid bits travel with the data. When the receiver stalls, the items move
// up into any empty stages and in_i.ready falls only once every stage holds
// an item; nothing is lost or repeated.
// The APB port holds idle throttle, output maximum, rotate enable and the
// orientation cosine and sine, and should be written only while the
// pipeline is empty. pready is always high.
// Reset empties the pipeline and loads the register defaults.
module quad_motor_mixer_with_headroom_rescale_core import qmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  qmm_in_if.sink           in_i,
  qmm_out_if.source        out_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{idle: IdleReset, omax: OmaxReset, rot: 1'b0, cs: CosReset, sn: SinReset};
    end else if (wr) begin
      unique case (idx)
        RegIdle:   cfg_q.idle <= pwdata[ThrW-1:0];
        RegOmax:   cfg_q.omax <= pwdata[ThrW-1:0];
        RegRotate: cfg_q.rot  <= pwdata[0];
        RegCos:    cfg_q.cs   <= pwdata[CosW-1:0];
        RegSin:    cfg_q.sn   <= pwdata[CosW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegIdle:   prdata = DataW'(cfg_q.idle);
      RegOmax:   prdata = DataW'(cfg_q.omax);
      RegRotate: prdata = DataW'(cfg_q.rot);
      RegCos:    prdata = DataW'(cfg_q.cs);
      RegSin:    prdata = DataW'(cfg_q.sn);
      default:   prdata = '0;
    endcase
  end

  qmm_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
